/* rtl/core/rmq_pkg.sv */
// shared widths, constants and sideband types for the rotation-to-quaternion block
// no dependencies
package rmq_pkg;

  localparam int FRAC_BITS = 30;
  localparam int IN_W      = 32;
  localparam int SUM_W     = IN_W + 2;
  localparam int DIF_W     = IN_W + 1;
  localparam int MAG_W     = IN_W + 1;
  localparam int RAD_W     = IN_W + 1;
  localparam int SQ_W      = RAD_W + FRAC_BITS + ((RAD_W + FRAC_BITS) % 2);
  localparam int RT_W      = SQ_W / 2;
  localparam int DIV_W     = RT_W + 1;
  localparam int DVD_W     = MAG_W + FRAC_BITS;

  localparam longint ONE_L   = longint'(1) << FRAC_BITS;
  localparam longint TENTH_L = (ONE_L + 5) / 10;

  typedef enum logic [1:0] {BR_W, BR_X, BR_Y, BR_Z} branch_t;

  typedef struct packed {
    branch_t                     br;
    logic                        bad;
    logic [2:0]                  neg;
    logic [2:0]                  nz;
    logic [2:0][MAG_W-1:0]       mag;
    logic [RT_W-2:0]             c;
    logic [2:0][IN_W-1:0]        pos;
  } side_t;

endpackage

/* rtl/core/rmq_sqrt.sv */
// pipelined integer square root, one result bit per stage
// depends on rmq_pkg
module rmq_sqrt (
  input  logic                      clk,
  input  logic                      en,
  input  logic [rmq_pkg::SQ_W-1:0]  op,
  output logic [rmq_pkg::RT_W-1:0]  root
);
  localparam int SQ_W = rmq_pkg::SQ_W;
  localparam int RT_W = rmq_pkg::RT_W;

  logic [SQ_W-1:0] op_r [RT_W];
  logic [RT_W-1:0] rt_r [RT_W];
  logic [RT_W+1:0] rm_r [RT_W];

  for (genvar k = 0; k < RT_W; k++) begin : g_st
    logic [SQ_W-1:0] op_i;
    logic [RT_W-1:0] rt_i;
    logic [RT_W+1:0] rm_i, t, trial;
    logic            ge;
    if (k == 0) begin : g_first
      assign op_i = op;
      assign rt_i = '0;
      assign rm_i = '0;
    end else begin : g_next
      assign op_i = op_r[k-1];
      assign rt_i = rt_r[k-1];
      assign rm_i = rm_r[k-1];
    end
    assign t     = {rm_i[RT_W-1:0], op_i[SQ_W-1 -: 2]};
    assign trial = {rt_i, 2'b01};
    assign ge    = (t >= trial);
    always_ff @(posedge clk) begin
      if (en) begin
        op_r[k] <= op_i << 2;
        rm_r[k] <= ge ? t - trial : t;
        rt_r[k] <= {rt_i[RT_W-2:0], ge};
      end
    end
  end

  assign root = rt_r[RT_W-1];

endmodule

/* rtl/core/rmq_div.sv */
// pipelined restoring divider, one quotient bit per stage
// depends on rmq_pkg
module rmq_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [rmq_pkg::DVD_W-1:0]  dvd,
  input  logic [rmq_pkg::DIV_W-1:0]  dv,
  output logic [rmq_pkg::DVD_W-1:0]  quo
);
  localparam int DVD_W = rmq_pkg::DVD_W;
  localparam int DIV_W = rmq_pkg::DIV_W;

  logic [DVD_W-1:0] dd_r [DVD_W];
  logic [DVD_W-1:0] q_r  [DVD_W];
  logic [DIV_W-1:0] dv_r [DVD_W];
  logic [DIV_W-1:0] rm_r [DVD_W];

  for (genvar k = 0; k < DVD_W; k++) begin : g_st
    logic [DVD_W-1:0] dd_i, q_i;
    logic [DIV_W-1:0] dv_i, rm_i;
    logic [DIV_W:0]   t, dx, dif;
    logic             ge;
    if (k == 0) begin : g_first
      assign dd_i = dvd;
      assign q_i  = '0;
      assign dv_i = dv;
      assign rm_i = '0;
    end else begin : g_next
      assign dd_i = dd_r[k-1];
      assign q_i  = q_r[k-1];
      assign dv_i = dv_r[k-1];
      assign rm_i = rm_r[k-1];
    end
    assign t   = {rm_i, dd_i[DVD_W-1]};
    assign dx  = {1'b0, dv_i};
    assign ge  = (t >= dx);
    assign dif = t - dx;
    always_ff @(posedge clk) begin
      if (en) begin
        dd_r[k] <= dd_i << 1;
        q_r[k]  <= {q_i[DVD_W-2:0], ge};
        dv_r[k] <= dv_i;
        rm_r[k] <= ge ? dif[DIV_W-1:0] : t[DIV_W-1:0];
      end
    end
  end

  assign quo = q_r[DVD_W-1];

endmodule

/* rtl/core/rotation_matrix_to_quaternion.sv */
// rotation matrix to unit quaternion, fully pipelined
// depends on rmq_pkg, rmq_sqrt, rmq_div
//
// takes one transform word per cycle (nine q2.30 rotation entries plus a raw position) and
// returns the quaternion w, x, y, z in q2.30 with the position copied through. the branch is
// chosen as in shepperd's method: the trace, then the three diagonal combinations, the first
// above -0.1 wins, else the last. the word passes stage 1 (sums), stage 2 (branch pick),
// the bit-per-stage square root (32 stages), the three parallel bit-per-stage dividers
// (63 stages) and the output register. one word enters per cycle; the whole pipeline holds while a finished word
// waits on out_stall. bad_matrix flags a negative radicand on the last branch; zero
// divisors saturate nonzero lanes by sign and give zero for zero lanes.
module rotation_matrix_to_quaternion (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_m00,
  input  logic signed [31:0] in_m10,
  input  logic signed [31:0] in_m20,
  input  logic signed [31:0] in_m01,
  input  logic signed [31:0] in_m11,
  input  logic signed [31:0] in_m21,
  input  logic signed [31:0] in_m02,
  input  logic signed [31:0] in_m12,
  input  logic signed [31:0] in_m22,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_quat_w,
  output logic signed [31:0] out_quat_x,
  output logic signed [31:0] out_quat_y,
  output logic signed [31:0] out_quat_z,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic               out_bad_matrix
);
  localparam int IN_W  = rmq_pkg::IN_W;
  localparam int SUM_W = rmq_pkg::SUM_W;
  localparam int DIF_W = rmq_pkg::DIF_W;
  localparam int MAG_W = rmq_pkg::MAG_W;
  localparam int RAD_W = rmq_pkg::RAD_W;
  localparam int SQ_W  = rmq_pkg::SQ_W;
  localparam int RT_W  = rmq_pkg::RT_W;
  localparam int DIV_W = rmq_pkg::DIV_W;
  localparam int DVD_W = rmq_pkg::DVD_W;
  localparam int FB    = rmq_pkg::FRAC_BITS;

  localparam logic signed [SUM_W-1:0] NEG_TENTH = -SUM_W'(rmq_pkg::TENTH_L);
  localparam logic signed [SUM_W:0]   ONE_S     = (SUM_W+1)'(rmq_pkg::ONE_L);
  localparam logic [DVD_W-1:0]        S_MAX     = DVD_W'(64'h7fff_ffff);
  localparam logic [DVD_W-1:0]        S_MINM    = DVD_W'(64'h8000_0000);
  localparam logic [IN_W-1:0]         Q_MAX     = IN_W'(64'h7fff_ffff);
  localparam logic [IN_W-1:0]         Q_MIN     = IN_W'(64'h8000_0000);

  // whole pipeline advances unless a finished word is held
  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // stage 1: trace, diagonal combinations and off-diagonal pairs
  logic                    vld1_r;
  logic signed [SUM_W-1:0] s0_r, s1_r, s2_r, s3_r;
  logic signed [DIF_W-1:0] da_r, db_r, dc_r, de_r, df_r, dg_r;
  logic [2:0][IN_W-1:0]    pos1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r <= SUM_W'(in_m00) + SUM_W'(in_m11) + SUM_W'(in_m22);
      s1_r <= SUM_W'(in_m00) - SUM_W'(in_m11) - SUM_W'(in_m22);
      s2_r <= -SUM_W'(in_m00) + SUM_W'(in_m11) - SUM_W'(in_m22);
      s3_r <= -SUM_W'(in_m00) - SUM_W'(in_m11) + SUM_W'(in_m22);
      da_r <= DIF_W'(in_m21) - DIF_W'(in_m12);
      db_r <= DIF_W'(in_m02) - DIF_W'(in_m20);
      dc_r <= DIF_W'(in_m10) - DIF_W'(in_m01);
      de_r <= DIF_W'(in_m10) + DIF_W'(in_m01);
      df_r <= DIF_W'(in_m20) + DIF_W'(in_m02);
      dg_r <= DIF_W'(in_m12) + DIF_W'(in_m21);
      pos1_r <= {in_pos_z, in_pos_y, in_pos_x};
    end
  end

  // stage 2: branch pick, radicand and lane magnitudes
  rmq_pkg::branch_t             br;
  logic signed [SUM_W-1:0]      s_sel;
  logic signed [SUM_W:0]        rad_s;
  logic                         bad;
  logic signed [DIF_W-1:0]      ld [3];
  rmq_pkg::side_t               side2_nxt, side2_r;
  logic                         vld2_r;
  logic [RAD_W-1:0]             rad2_nxt, rad2_r;

  always_comb begin
    if (s0_r > NEG_TENTH) begin
      br = rmq_pkg::BR_W;
    end else if (s1_r > NEG_TENTH) begin
      br = rmq_pkg::BR_X;
    end else if (s2_r > NEG_TENTH) begin
      br = rmq_pkg::BR_Y;
    end else begin
      br = rmq_pkg::BR_Z;
    end
    case (br)
      rmq_pkg::BR_W: begin
        s_sel = s0_r; ld[0] = da_r; ld[1] = db_r; ld[2] = dc_r;
      end
      rmq_pkg::BR_X: begin
        s_sel = s1_r; ld[0] = da_r; ld[1] = de_r; ld[2] = df_r;
      end
      rmq_pkg::BR_Y: begin
        s_sel = s2_r; ld[0] = db_r; ld[1] = de_r; ld[2] = dg_r;
      end
      default: begin
        s_sel = s3_r; ld[0] = dc_r; ld[1] = df_r; ld[2] = dg_r;
      end
    endcase
    rad_s    = ONE_S + (SUM_W+1)'(s_sel);
    bad      = (br == rmq_pkg::BR_Z) && rad_s[SUM_W];
    rad2_nxt = bad ? '0 : rad_s[RAD_W-1:0];
    side2_nxt     = '0;
    side2_nxt.br  = br;
    side2_nxt.bad = bad;
    side2_nxt.pos = pos1_r;
    for (int i = 0; i < 3; i++) begin
      logic signed [DIF_W:0] dx, mx;
      dx = (DIF_W+1)'(ld[i]);
      mx = ld[i][DIF_W-1] ? -dx : dx;
      side2_nxt.neg[i] = ld[i][DIF_W-1];
      side2_nxt.nz[i]  = (ld[i] != '0);
      side2_nxt.mag[i] = mx[MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else if (en) begin
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side2_r <= side2_nxt;
      rad2_r  <= rad2_nxt;
    end
  end

  // square root stages, sideband travels alongside
  logic [RT_W-1:0]  root;
  logic [RT_W-1:0]  sq_v_r;
  rmq_pkg::side_t   sq_sd_r [RT_W];

  rmq_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .op   (SQ_W'({rad2_r, {FB{1'b0}}})),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r <= '0;
    end else if (en) begin
      sq_v_r <= {sq_v_r[RT_W-2:0], vld2_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_sd_r[0] <= side2_r;
      for (int k = 1; k < RT_W; k++) begin
        sq_sd_r[k] <= sq_sd_r[k-1];
      end
    end
  end

  // divider stages: three lanes share the divisor 4c
  rmq_pkg::side_t   dv_in;
  logic [DIV_W-1:0] divisor;
  logic [DVD_W-1:0] quo [3];
  logic [DVD_W-1:0] dv_v_r;
  rmq_pkg::side_t   dv_sd_r [DVD_W];

  always_comb begin
    dv_in   = sq_sd_r[RT_W-1];
    dv_in.c = root[RT_W-1:1];
    divisor = {root[RT_W-1:1], 2'b00};
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    rmq_div u_div (
      .clk (clk),
      .en  (en),
      .dvd ({dv_in.mag[i], {FB{1'b0}}}),
      .dv  (divisor),
      .quo (quo[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r <= '0;
    end else if (en) begin
      dv_v_r <= {dv_v_r[DVD_W-2:0], sq_v_r[RT_W-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_sd_r[0] <= dv_in;
      for (int k = 1; k < DVD_W; k++) begin
        dv_sd_r[k] <= dv_sd_r[k-1];
      end
    end
  end

  // saturation, zero-divisor handling and placement
  function automatic logic [IN_W-1:0] sat_q(input logic [DVD_W-1:0] q, input logic neg,
                                            input logic nz, input logic dz);
    logic [IN_W-1:0] r;
    if (dz) begin
      r = nz ? (neg ? Q_MIN : Q_MAX) : '0;
    end else if (neg) begin
      r = (q > S_MINM) ? Q_MIN : -q[IN_W-1:0];
    end else begin
      r = (q > S_MAX) ? Q_MAX : q[IN_W-1:0];
    end
    return r;
  endfunction

  rmq_pkg::side_t        fin;
  logic [IN_W-1:0]       lq [3];
  logic [IN_W-1:0]       cq;
  logic [3:0][IN_W-1:0]  quat_nxt, quat_r;
  logic [2:0][IN_W-1:0]  pos_r;
  logic                  bad_r, out_valid_r;

  always_comb begin
    fin = dv_sd_r[DVD_W-1];
    cq  = IN_W'(fin.c);
    for (int i = 0; i < 3; i++) begin
      lq[i] = sat_q(quo[i], fin.neg[i], fin.nz[i], fin.c == '0);
    end
    case (fin.br)
      rmq_pkg::BR_W: quat_nxt = {lq[2], lq[1], lq[0], cq};
      rmq_pkg::BR_X: quat_nxt = {lq[2], lq[1], cq, lq[0]};
      rmq_pkg::BR_Y: quat_nxt = {lq[2], cq, lq[1], lq[0]};
      default:       quat_nxt = {cq, lq[2], lq[1], lq[0]};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_v_r[DVD_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quat_r <= quat_nxt;
      pos_r  <= fin.pos;
      bad_r  <= fin.bad;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_quat_w     = quat_r[0];
  assign out_quat_x     = quat_r[1];
  assign out_quat_y     = quat_r[2];
  assign out_quat_z     = quat_r[3];
  assign out_pos_x      = pos_r[0];
  assign out_pos_y      = pos_r[1];
  assign out_pos_z      = pos_r[2];
  assign out_bad_matrix = bad_r;

  // a held pipeline keeps the stage-2, square-root and divider valid bits
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> ($stable(sq_v_r) && $stable(dv_v_r) && $stable(vld2_r)))
    else $error("pipeline valid bits moved while held");

  // clamped radicand gives a zero z component
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && bad_r) |-> (quat_r[3] == '0))
    else $error("bad matrix word with nonzero z");

  // the flag only rides on the last branch
  a_bad_br: assert property (@(posedge clk) disable iff (!rst_n)
    (vld2_r && side2_r.bad) |-> (side2_r.br == rmq_pkg::BR_Z && rad2_r == '0))
    else $error("bad flag outside the last branch");

endmodule
